// File: rtl/ambient_light_change_detector_defines.svh
// Assertion macros for the ambient light change detector.
`ifndef AMBIENT_LIGHT_CHANGE_DETECTOR_DEFINES_SVH
`define AMBIENT_LIGHT_CHANGE_DETECTOR_DEFINES_SVH

`ifndef SYNTHESIS
`define ALCD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("alcd assertion failed");
`define ALCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("alcd assertion failed");
`else
`define ALCD_ASSERT(lbl, prop)
`define ALCD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/alcd_pkg.sv
// Shared constants and types of the ambient light change detector.
`timescale 1ns / 1ps
`default_nettype none

package alcd_pkg;

  localparam int unsigned DELTA_BITS = 10;
  localparam logic [DELTA_BITS-1:0] DELTA_RESET = 10'd100;

  localparam logic [1:0] STATE_SAME    = 2'd0;
  localparam logic [1:0] STATE_DARKER  = 2'd1;
  localparam logic [1:0] STATE_LIGHTER = 2'd2;

  typedef struct packed {
    logic filled_now;
    logic filled_next;
  } win_stat_t;

endpackage

`default_nettype wire

// File: rtl/alcd_cell.sv
// One window cell: holds a sample and hands it to the next cell on a shift.
`timescale 1ns / 1ps
`default_nettype none

module alcd_cell #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   shift_i,
  input  wire logic [SAMPLE_BITS-1:0] data_i,
  output logic      [SAMPLE_BITS-1:0] data_o
);

  logic [SAMPLE_BITS-1:0] data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (shift_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

// File: rtl/alcd_window.sv
// Sample window: row of cells, running sum, fill tracking and average.
`timescale 1ns / 1ps
`default_nettype none

module alcd_window #(
  parameter int unsigned WINDOW_DEPTH = 8,
  parameter int unsigned SAMPLE_BITS  = 10
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   shift_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  output logic      [SAMPLE_BITS-1:0] average_o,
  output alcd_pkg::win_stat_t         stat_o
);

  localparam int unsigned SumW  = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
  localparam int unsigned PosW  = $clog2(WINDOW_DEPTH);
  localparam int unsigned Shift = $clog2(WINDOW_DEPTH + 1) - 1;
  localparam logic [PosW-1:0] LastPos = PosW'(WINDOW_DEPTH - 1);

  logic [SAMPLE_BITS-1:0] tap [WINDOW_DEPTH+1];
  logic [SumW-1:0]        sum_q, sum_d, sum_shr;
  logic [PosW-1:0]        pos_q, pos_d;
  logic                   filled_q, filled_d;

  assign tap[0] = sample_i;

  for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
    alcd_cell #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift_i),
      .data_i (tap[g]),
      .data_o (tap[g+1])
    );
  end

  always_comb begin
    sum_d    = sum_q - SumW'(tap[WINDOW_DEPTH]) + SumW'(sample_i);
    sum_shr  = sum_d >> Shift;
    pos_d    = (pos_q == LastPos) ? '0 : pos_q + 1'b1;
    filled_d = filled_q | (pos_q == LastPos);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      pos_q    <= '0;
      filled_q <= 1'b0;
    end else if (shift_i) begin
      sum_q    <= sum_d;
      pos_q    <= pos_d;
      filled_q <= filled_d;
    end
  end

  assign average_o          = sum_shr[SAMPLE_BITS-1:0];
  assign stat_o.filled_now  = filled_q;
  assign stat_o.filled_next = filled_d;

endmodule

`default_nettype wire

// File: rtl/ambient_light_change_detector.sv
// Ambient light change detector: top level with extremes, state and output register.
//
// Each accepted sample word yields one result word in the next cycle; a new sample is
// taken every cycle while the output register is empty or being drained. The window
// is a row of WINDOW_DEPTH shift cells, cleared to zero at reset, with a running sum
// updated by the entering and leaving samples, so the rate does not depend on depth.
// Average is the sum shifted right by floor(log2(WINDOW_DEPTH)); max and min track
// all samples since reset. The light state is judged against delta_q only from
// the sample after the window first wraps, and holds until then.
`timescale 1ns / 1ps
`default_nettype none

`include "ambient_light_change_detector_defines.svh"

module ambient_light_change_detector #(
  parameter int unsigned WINDOW_DEPTH = 8,
  parameter int unsigned SAMPLE_BITS  = 10
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  cfg_we_i,
  input  wire logic [alcd_pkg::DELTA_BITS-1:0]       cfg_wdata_i,
  input  wire logic                                  s_axis_tvalid,
  output logic                                       s_axis_tready,
  // sample
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]      s_axis_tdata,
  output logic                                       m_axis_tvalid,
  input  wire logic                                  m_axis_tready,
  // average, max_seen, min_seen, ambient_state, window_full
  output logic      [((3*SAMPLE_BITS+10)/8)*8-1:0]   m_axis_tdata
);

  localparam int unsigned OutW   = 3 * SAMPLE_BITS + 3;
  localparam int unsigned OutPadW = ((3 * SAMPLE_BITS + 10) / 8) * 8;
  localparam int unsigned CmpW   = (SAMPLE_BITS > alcd_pkg::DELTA_BITS) ?
                                   SAMPLE_BITS : alcd_pkg::DELTA_BITS;

  logic                            accept;
  logic [SAMPLE_BITS-1:0]          sample;
  logic [SAMPLE_BITS-1:0]          average;
  alcd_pkg::win_stat_t             win_stat;

  logic [alcd_pkg::DELTA_BITS-1:0] delta_q;
  logic [SAMPLE_BITS-1:0]          max_q, max_d, min_q, min_d, span;
  logic [1:0]                      state_q, state_d;
  logic                            out_valid_q;
  logic [OutW-1:0]                 out_data_q;

  assign sample        = s_axis_tdata[SAMPLE_BITS-1:0];
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  alcd_window #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (accept),
    .sample_i (sample),
    .average_o(average),
    .stat_o   (win_stat)
  );

  always_comb begin
    max_d   = (sample > max_q) ? sample : max_q;
    min_d   = (sample < min_q) ? sample : min_q;
    span    = (max_d >= min_d) ? (max_d - min_d) : '0;
    state_d = state_q;
    if (win_stat.filled_now) begin
      if (CmpW'(span) > CmpW'(delta_q)) begin
        state_d = (max_d == sample) ? alcd_pkg::STATE_DARKER : alcd_pkg::STATE_LIGHTER;
      end else begin
        state_d = alcd_pkg::STATE_SAME;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_q <= alcd_pkg::DELTA_RESET;
    end else if (cfg_we_i) begin
      delta_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q   <= '0;
      min_q   <= '1;
      state_q <= alcd_pkg::STATE_SAME;
    end else if (accept) begin
      max_q   <= max_d;
      min_q   <= min_d;
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {win_stat.filled_next, state_d, min_d, max_d, average};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutPadW'(out_data_q);

  `ALCD_ASSERT(a_min_le_max, !out_valid_q || (min_q <= max_q))
  `ALCD_ASSERT(a_same_until_full, win_stat.filled_now || (state_q == alcd_pkg::STATE_SAME))
  `ALCD_ASSERT(a_no_overwrite, !accept || !out_valid_q || m_axis_tready)
  `ALCD_ASSERT_NEXT(a_full_sticks, win_stat.filled_now, win_stat.filled_now)

endmodule

`default_nettype wire
